@@ hdl/ppa_pkg.sv @@
`default_nettype none
package ppa_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int CX_STEPS     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int SQ_CELLS     = 17;
   localparam int CW           = 34;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NZERO    = 2'd1;
   localparam logic [1:0] ST_PARALLEL = 2'd2;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] hub_x;
      logic signed [31:0] hub_y;
      logic signed [31:0] hub_z;
   } ppa_req_type;

   // sideband that rides along the square root chain
   typedef struct packed {
      logic [1:0]         status;
      logic               on_z;
      logic               nz_pos;
      logic signed [30:0] rsx;
      logic signed [30:0] rsy;
      logic signed [47:0] x;
      logic signed [63:0] y;
   } ppa_sq_side_type;

   typedef struct packed {
      logic [33:0] rad;
      logic [20:0] rem;
      logic [16:0] root;
   } ppa_sq_type;

   typedef struct packed {
      logic [1:0] status;
      logic       vzero;
   } ppa_cx_side_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [31:0]          z;
   } ppa_cx_type;

   function automatic logic [6:0] msb_pos(input logic [63:0] v);
      logic [6:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            p = 7'(i);
         end
      end
      return p;
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      return m;
   endfunction

   // shift right, rounding toward zero
   function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
                                                 input logic [5:0] k);
      logic [63:0] m;
      m = abs64(v) >> k;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   // shift that keeps the largest magnitude below 2^30
   function automatic logic [5:0] down_shift(input logic [63:0] mx);
      logic [6:0] p;
      p = msb_pos(mx);
      return (p > 7'd29) ? 6'(p - 7'd29) : 6'd0;
   endfunction

   function automatic logic [31:0] atan_at(input logic [4:0] i);
      logic [31:0] a;
      unique case (i)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

@@ hdl/ppa_channels.sv @@
`default_nettype none
interface ppa_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_z;
   logic signed [31:0] hub_x;
   logic signed [31:0] hub_y;
   logic signed [31:0] hub_z;
   modport source(output valid, normal_x, normal_y, normal_z, target_x, target_y,
                  target_z, hub_x, hub_y, hub_z, input ready);
   modport sink(input valid, normal_x, normal_y, normal_z, target_x, target_y,
                target_z, hub_x, hub_y, hub_z, output ready);
endinterface

interface ppa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] phase;
   logic [1:0]         status;
   modport source(output valid, phase, status, input ready);
   modport sink(input valid, phase, status, output ready);
endinterface
`default_nettype wire

@@ hdl/plane_phase_angle_top.sv @@
`default_nettype none
// channel   dir  handshake      payload
// req_ch    in   valid/ready    normal_x/y/z, target_x/y/z, hub_x/y/z
// rsp_ch    out  valid/ready    phase, status
//
// one transaction accepted per cycle while the pipeline advances; the path runs through
// 7 front stages, 17 square root cells, 4 scaling stages, the CORDIC cells and the output
// the whole pipeline advances together; it holds only while the output register
// is full and not taken
// synchronous reset clears valid bits only
module plane_phase_angle_top (
   input wire logic   clock,
   input wire logic   reset,
   ppa_req_if.sink    req_ch,
   ppa_rsp_if.source  rsp_ch
);
   import ppa_pkg::*;

   logic        adv;
   ppa_req_type req;
   logic        fr_valid;
   ppa_sq_side_type fr_side;
   logic [32:0] fr_n2;

   logic            sq_valid [SQ_CELLS+1];
   ppa_sq_type      sq_data  [SQ_CELLS+1];
   ppa_sq_side_type sq_side  [SQ_CELLS+1];

   // scaling stages
   logic [3:0]         sv_ff, sv_in;
   logic signed [63:0] mX_ff, mY_ff, mX_in, mY_in;
   logic [1:0]         mst_ff, n1st_ff, n2st_ff, n3st_ff;
   logic signed [63:0] n1X_ff, n1Y_ff, n2X_ff, n2Y_ff;
   logic [63:0]        n1mx_ff, n1mx_in;
   logic [5:0]         n2k_ff;
   logic signed [CW-1:0] n3X_ff, n3Y_ff;
   logic               n3z_ff;

   logic            cx_valid [CX_STEPS+1];
   ppa_cx_type      cx_data  [CX_STEPS+1];
   ppa_cx_side_type cx_side  [CX_STEPS+1];

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_phase_ff, rsp_phase_in;
   logic [1:0]         rsp_status_ff;
   logic [31:0]        zr;

   // pipeline advances unless a result is stuck at the output
   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_comb begin
      req.normal_x = req_ch.normal_x;
      req.normal_y = req_ch.normal_y;
      req.normal_z = req_ch.normal_z;
      req.target_x = req_ch.target_x;
      req.target_y = req_ch.target_y;
      req.target_z = req_ch.target_z;
      req.hub_x    = req_ch.hub_x;
      req.hub_y    = req_ch.hub_y;
      req.hub_z    = req_ch.hub_z;
   end

   ppa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .in_req    (req),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_n2    (fr_n2)
   );

   // square root of |n|^2, one bit per cell
   assign sq_valid[0]     = fr_valid;
   assign sq_data[0].rad  = {1'b0, fr_n2};
   assign sq_data[0].rem  = '0;
   assign sq_data[0].root = '0;
   assign sq_side[0]      = fr_side;

   for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
      ppa_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_valid[g]),
         .in_sq     (sq_data[g]),
         .in_side   (sq_side[g]),
         .out_valid (sq_valid[g+1]),
         .out_sq    (sq_data[g+1]),
         .out_side  (sq_side[g+1])
      );
   end

   // vector selection and scaling
   always_comb begin
      if (sq_side[SQ_CELLS].on_z) begin
         mX_in = sq_side[SQ_CELLS].nz_pos ? -64'(sq_side[SQ_CELLS].rsx)
                                          : 64'(sq_side[SQ_CELLS].rsx);
         mY_in = -64'(sq_side[SQ_CELLS].rsy);
      end else begin
         mX_in = sq_side[SQ_CELLS].x * $signed({1'b0, sq_data[SQ_CELLS].root});
         mY_in = sq_side[SQ_CELLS].y;
      end
      n1mx_in = abs64(mX_ff);
      if (abs64(mY_ff) > n1mx_in) begin
         n1mx_in = abs64(mY_ff);
      end
   end

   assign sv_in = {sv_ff[2:0], sq_valid[SQ_CELLS]};

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else if (adv) begin
         sv_ff <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mX_ff   <= mX_in;
         mY_ff   <= mY_in;
         mst_ff  <= sq_side[SQ_CELLS].status;
         n1X_ff  <= mX_ff;
         n1Y_ff  <= mY_ff;
         n1mx_ff <= n1mx_in;
         n1st_ff <= mst_ff;
         n2X_ff  <= n1X_ff;
         n2Y_ff  <= n1Y_ff;
         n2k_ff  <= down_shift(n1mx_ff);
         n2st_ff <= n1st_ff;
         n3X_ff  <= CW'(shr_tz(n2X_ff, n2k_ff));
         n3Y_ff  <= CW'(shr_tz(n2Y_ff, n2k_ff));
         n3st_ff <= n2st_ff;
      end
   end

   assign n3z_ff = 1'b0;

   // fold the left half plane onto the right one
   always_comb begin
      cx_valid[0] = sv_ff[3];
      if (n3X_ff < 0) begin
         cx_data[0].x = -n3X_ff;
         cx_data[0].y = -n3Y_ff;
         cx_data[0].z = 32'h80000000;
      end else begin
         cx_data[0].x = n3X_ff;
         cx_data[0].y = n3Y_ff;
         cx_data[0].z = 32'h0;
      end
      cx_side[0].status = n3st_ff;
      cx_side[0].vzero  = (n3X_ff == '0) && (n3Y_ff == '0) || n3z_ff;
   end

   for (genvar g = 0; g < CX_STEPS; g++) begin : g_cx
      ppa_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step_idx  (5'(g)),
         .in_valid  (cx_valid[g]),
         .in_cx     (cx_data[g]),
         .in_side   (cx_side[g]),
         .out_valid (cx_valid[g+1]),
         .out_cx    (cx_data[g+1]),
         .out_side  (cx_side[g+1])
      );
   end

   // round the angle to 16 bits
   always_comb begin
      zr = cx_data[CX_STEPS].z + 32'h8000;
      if (cx_side[CX_STEPS].status != ST_OK || cx_side[CX_STEPS].vzero) begin
         rsp_phase_in = 16'sd0;
      end else begin
         rsp_phase_in = $signed(zr[31:16]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cx_valid[CX_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_phase_ff  <= rsp_phase_in;
         rsp_status_ff <= cx_side[CX_STEPS].status;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.phase  = rsp_phase_ff;
   assign rsp_ch.status = rsp_status_ff;

   a_flag_zero_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_phase_ff == 16'sd0)
      else $error("flagged result with nonzero phase");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while output stalled");

   a_last_cell_to_output: assert property (@(posedge clock) disable iff (reset)
      adv && cx_valid[CX_STEPS] |=> rsp_valid_ff)
      else $error("result lost between CORDIC chain and output");

   a_held_output: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(rsp_phase_ff) && $stable(cx_data[CX_STEPS].z))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

@@ hdl/ppa_front.sv @@
`default_nettype none
module ppa_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  ppa_pkg::ppa_req_type       in_req,
   output logic                       out_valid,
   output ppa_pkg::ppa_sq_side_type   out_side,
   output logic [32:0]                out_n2
);
   import ppa_pkg::*;

   logic [6:0] v_ff, v_in;

   // stage 1: radial vector
   logic signed [32:0] rx1_ff, ry1_ff, rz1_ff, rx1_in, ry1_in, rz1_in;
   logic signed [15:0] nx1_ff, ny1_ff, nz1_ff;

   // stage 2: cross products and shift amounts
   logic signed [48:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic signed [48:0] c1_in, c2_in, c3_in, c4_in, c5_in, c6_in;
   logic signed [32:0] rx2_ff, ry2_ff, rz2_ff;
   logic signed [15:0] nx2_ff, ny2_ff, nz2_ff;
   logic [5:0]         rk2_ff, rk2_in;
   logic [3:0]         nk2_ff, nk2_in;
   logic               nzero2_ff, nzero2_in, onz2_ff;
   logic [63:0]        rmx, nmx;
   logic [6:0]         npos;

   // stage 3: status, scaled radial, scaled normal
   logic [1:0]         st3_ff, st3_in;
   logic               onz3_ff;
   logic signed [30:0] rsx3_ff, rsy3_ff, rsz3_ff, rsx3_in, rsy3_in, rsz3_in;
   logic signed [15:0] nx3_ff, ny3_ff, nz3_ff, nx3_in, ny3_in, nz3_in;

   // stage 4: products
   logic signed [47:0] a4_ff, b4_ff, c4p_ff, d4_ff, a4_in, b4_in, c4p_in, d4_in;
   logic signed [31:0] nxx4_ff, nyy4_ff, nzz4_ff, nxx4_in, nyy4_in, nzz4_in;
   logic [1:0]         st4_ff;
   logic               onz4_ff, nzp4_ff;
   logic signed [30:0] rsx4_ff, rsy4_ff, rsz4_ff;
   logic signed [15:0] nz4_ff;

   // stage 5: sums
   logic signed [47:0] x5_ff, s5_ff, x5_in, s5_in;
   logic [31:0]        q5_ff, q5_in;
   logic [32:0]        n25_ff, n25_in;
   logic [1:0]         st5_ff;
   logic               onz5_ff, nzp5_ff;
   logic signed [30:0] rsx5_ff, rsy5_ff, rsz5_ff;
   logic signed [15:0] nz5_ff;

   // stage 6: products for y
   logic signed [63:0] ys1_6_ff, ys2_6_ff, ys1_6_in, ys2_6_in;
   logic signed [47:0] x6_ff;
   logic [32:0]        n26_ff;
   logic [1:0]         st6_ff;
   logic               onz6_ff, nzp6_ff;
   logic signed [30:0] rsx6_ff, rsy6_ff;

   // stage 7: y difference
   ppa_sq_side_type    side7_ff, side7_in;
   logic [32:0]        n27_ff;

   assign v_in = {v_ff[5:0], in_valid};

   // stage 1 logic
   assign rx1_in = 33'(in_req.target_x) - 33'(in_req.hub_x);
   assign ry1_in = 33'(in_req.target_y) - 33'(in_req.hub_y);
   assign rz1_in = 33'(in_req.target_z) - 33'(in_req.hub_z);

   // stage 2 logic
   always_comb begin
      c1_in = ny1_ff * rz1_ff;
      c2_in = nz1_ff * ry1_ff;
      c3_in = nz1_ff * rx1_ff;
      c4_in = nx1_ff * rz1_ff;
      c5_in = nx1_ff * ry1_ff;
      c6_in = ny1_ff * rx1_ff;
      rmx = abs64(64'(rx1_ff));
      if (abs64(64'(ry1_ff)) > rmx) begin
         rmx = abs64(64'(ry1_ff));
      end
      if (abs64(64'(rz1_ff)) > rmx) begin
         rmx = abs64(64'(rz1_ff));
      end
      rk2_in = down_shift(rmx);
      nmx = abs64(64'(nx1_ff));
      if (abs64(64'(ny1_ff)) > nmx) begin
         nmx = abs64(64'(ny1_ff));
      end
      if (abs64(64'(nz1_ff)) > nmx) begin
         nmx = abs64(64'(nz1_ff));
      end
      npos = msb_pos(nmx);
      nzero2_in = (nmx == 64'd0);
      if (nzero2_in || npos >= 7'd14) begin
         nk2_in = 4'd0;
      end else begin
         nk2_in = 4'(7'd14 - npos);
      end
   end

   // stage 3 logic
   always_comb begin
      if (nzero2_ff) begin
         st3_in = ST_NZERO;
      end else if (c1_ff == c2_ff && c3_ff == c4_ff && c5_ff == c6_ff) begin
         st3_in = ST_PARALLEL;
      end else begin
         st3_in = ST_OK;
      end
      rsx3_in = 31'(shr_tz(64'(rx2_ff), rk2_ff));
      rsy3_in = 31'(shr_tz(64'(ry2_ff), rk2_ff));
      rsz3_in = 31'(shr_tz(64'(rz2_ff), rk2_ff));
      nx3_in = nx2_ff <<< nk2_ff;
      ny3_in = ny2_ff <<< nk2_ff;
      nz3_in = nz2_ff <<< nk2_ff;
   end

   // stage 4 logic
   assign a4_in   = ny3_ff * rsx3_ff;
   assign b4_in   = nx3_ff * rsy3_ff;
   assign c4p_in  = nx3_ff * rsx3_ff;
   assign d4_in   = ny3_ff * rsy3_ff;
   assign nxx4_in = nx3_ff * nx3_ff;
   assign nyy4_in = ny3_ff * ny3_ff;
   assign nzz4_in = nz3_ff * nz3_ff;

   // stage 5 logic
   assign x5_in  = a4_ff - b4_ff;
   assign s5_in  = c4p_ff + d4_ff;
   assign q5_in  = 32'(nxx4_ff) + 32'(nyy4_ff);
   assign n25_in = 33'(q5_in) + 33'(nzz4_ff);

   // stage 6 logic
   assign ys1_6_in = nz5_ff * s5_ff;
   assign ys2_6_in = $signed({1'b0, q5_ff}) * rsz5_ff;

   // stage 7 logic
   always_comb begin
      side7_in.status = st6_ff;
      side7_in.on_z   = onz6_ff;
      side7_in.nz_pos = nzp6_ff;
      side7_in.rsx    = rsx6_ff;
      side7_in.rsy    = rsy6_ff;
      side7_in.x      = x6_ff;
      side7_in.y      = ys1_6_ff - ys2_6_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         rx1_ff <= rx1_in;
         ry1_ff <= ry1_in;
         rz1_ff <= rz1_in;
         nx1_ff <= in_req.normal_x;
         ny1_ff <= in_req.normal_y;
         nz1_ff <= in_req.normal_z;

         c1_ff <= c1_in;
         c2_ff <= c2_in;
         c3_ff <= c3_in;
         c4_ff <= c4_in;
         c5_ff <= c5_in;
         c6_ff <= c6_in;
         rx2_ff <= rx1_ff;
         ry2_ff <= ry1_ff;
         rz2_ff <= rz1_ff;
         nx2_ff <= nx1_ff;
         ny2_ff <= ny1_ff;
         nz2_ff <= nz1_ff;
         rk2_ff <= rk2_in;
         nk2_ff <= nk2_in;
         nzero2_ff <= nzero2_in;
         onz2_ff <= (nx1_ff == 16'sd0) && (ny1_ff == 16'sd0);

         st3_ff  <= st3_in;
         onz3_ff <= onz2_ff;
         rsx3_ff <= rsx3_in;
         rsy3_ff <= rsy3_in;
         rsz3_ff <= rsz3_in;
         nx3_ff  <= nx3_in;
         ny3_ff  <= ny3_in;
         nz3_ff  <= nz3_in;

         a4_ff   <= a4_in;
         b4_ff   <= b4_in;
         c4p_ff  <= c4p_in;
         d4_ff   <= d4_in;
         nxx4_ff <= nxx4_in;
         nyy4_ff <= nyy4_in;
         nzz4_ff <= nzz4_in;
         st4_ff  <= st3_ff;
         onz4_ff <= onz3_ff;
         nzp4_ff <= (nz3_ff > 16'sd0);
         rsx4_ff <= rsx3_ff;
         rsy4_ff <= rsy3_ff;
         rsz4_ff <= rsz3_ff;
         nz4_ff  <= nz3_ff;

         x5_ff   <= x5_in;
         s5_ff   <= s5_in;
         q5_ff   <= q5_in;
         n25_ff  <= n25_in;
         st5_ff  <= st4_ff;
         onz5_ff <= onz4_ff;
         nzp5_ff <= nzp4_ff;
         rsx5_ff <= rsx4_ff;
         rsy5_ff <= rsy4_ff;
         rsz5_ff <= rsz4_ff;
         nz5_ff  <= nz4_ff;

         ys1_6_ff <= ys1_6_in;
         ys2_6_ff <= ys2_6_in;
         x6_ff    <= x5_ff;
         n26_ff   <= n25_ff;
         st6_ff   <= st5_ff;
         onz6_ff  <= onz5_ff;
         nzp6_ff  <= nzp5_ff;
         rsx6_ff  <= rsx5_ff;
         rsy6_ff  <= rsy5_ff;

         side7_ff <= side7_in;
         n27_ff   <= n26_ff;
      end
   end

   assign out_valid = v_ff[6];
   assign out_side  = side7_ff;
   assign out_n2    = n27_ff;

endmodule
`default_nettype wire

@@ hdl/ppa_sqrt_cell.sv @@
`default_nettype none
module ppa_sqrt_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  ppa_pkg::ppa_sq_type        in_sq,
   input  ppa_pkg::ppa_sq_side_type   in_side,
   output logic                       out_valid,
   output ppa_pkg::ppa_sq_type        out_sq,
   output ppa_pkg::ppa_sq_side_type   out_side
);
   import ppa_pkg::*;

   logic            valid_ff;
   ppa_sq_type      sq_ff, sq_in;
   ppa_sq_side_type side_ff;
   logic [20:0]     rem_t, trial;

   // one result bit per cell
   always_comb begin
      rem_t = {in_sq.rem[18:0], in_sq.rad[33:32]};
      trial = {2'b00, in_sq.root, 2'b01};
      sq_in.rad = {in_sq.rad[31:0], 2'b00};
      if (rem_t >= trial) begin
         sq_in.rem  = rem_t - trial;
         sq_in.root = {in_sq.root[15:0], 1'b1};
      end else begin
         sq_in.rem  = rem_t;
         sq_in.root = {in_sq.root[15:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff   <= sq_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_sq    = sq_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

@@ hdl/ppa_cordic_cell.sv @@
`default_nettype none
module ppa_cordic_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic [4:0]            step_idx,
   input  wire logic                  in_valid,
   input  ppa_pkg::ppa_cx_type        in_cx,
   input  ppa_pkg::ppa_cx_side_type   in_side,
   output logic                       out_valid,
   output ppa_pkg::ppa_cx_type        out_cx,
   output ppa_pkg::ppa_cx_side_type   out_side
);
   import ppa_pkg::*;

   logic            valid_ff;
   ppa_cx_type      cx_ff, cx_in;
   ppa_cx_side_type side_ff;
   logic signed [CW-1:0] dx, dy;

   // one vectoring rotation, driving y toward zero
   always_comb begin
      dx = in_cx.y >>> step_idx;
      dy = in_cx.x >>> step_idx;
      if (in_cx.y > 0) begin
         cx_in.x = in_cx.x + dx;
         cx_in.y = in_cx.y - dy;
         cx_in.z = in_cx.z + atan_at(step_idx);
      end else begin
         cx_in.x = in_cx.x - dx;
         cx_in.y = in_cx.y + dy;
         cx_in.z = in_cx.z - atan_at(step_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff   <= cx_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_cx    = cx_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire
